[src/ccc_pkg.sv]
// Shared types, constants and the arctangent table function for the coordinate converter.
`timescale 1ns / 1ps
`default_nettype none
package ccc_pkg;

  // Internal angle width (turn fractions) and vector component width (signed Q30).
  localparam int AW = 64;
  localparam int CW = 33;

  localparam logic signed [30:0] INV_GAIN = 31'sh26DD3B6A;
  localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1 << 30);
  localparam logic signed [CW-1:0] POLE_EPS = CW'(64'sd64);
  localparam logic [AW-1:0] QUARTER = 64'h4000_0000_0000_0000;
  localparam logic [AW-1:0] HALF_TURN = 64'h8000_0000_0000_0000;
  localparam logic [AW-1:0] THREE_QUARTER = 64'hC000_0000_0000_0000;
  localparam logic [AW-1:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

  typedef enum logic [2:0] {
    MODE_HOR_EQ1 = 3'd0,
    MODE_EQ1_HOR = 3'd1,
    MODE_EQ_SWAP = 3'd2,
    MODE_HOR_EQ2 = 3'd3,
    MODE_EQ2_HOR = 3'd4
  } mode_t;

  // atan(2^-idx) in 2^-64 turns: truncated Taylor series times 1/(2 pi), high half.
  function automatic logic [AW-1:0] atan_entry(input int idx);
    logic [AW-1:0] sum;
    logic [AW-1:0] term;
    logic [2*AW-1:0] prod;
    int k;
    sum = '0;
    if (idx == 0) begin
      return 64'h2000_0000_0000_0000;
    end
    for (k = 0; idx * (2 * k + 1) <= 63; k++) begin
      term = (64'd1 << (64 - idx * (2 * k + 1))) / 64'(2 * k + 1);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    prod = {64'd0, sum} * {64'd0, INV_TWO_PI_Q64};
    return prod[2*AW-1:AW];
  endfunction

endpackage
`default_nettype wire

[src/ccc_cordic.sv]
// Pipelined CORDIC unit: rotation or vectoring, one stage per iteration, gain compensated.
`timescale 1ns / 1ps
`default_nettype none
module ccc_cordic import ccc_pkg::*; #(
  parameter bit VECTOR = 1'b0,
  parameter int STAGES = 30,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_flag,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic [AW-1:0]        in_ang,
  input  logic [SBW-1:0]       in_sb,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic [AW-1:0]        out_ang,
  output logic [SBW-1:0]       out_sb
);

  logic signed [CW-1:0] x_r [STAGES+1];
  logic signed [CW-1:0] y_r [STAGES+1];
  logic [AW-1:0]        z_r [STAGES+1];
  logic signed [CW-1:0] xo_r [STAGES+1];
  logic signed [CW-1:0] yo_r [STAGES+1];
  logic                 flag_r [STAGES+1];
  logic [SBW-1:0]       sb_r [STAGES+1];
  logic                 v_r [STAGES+1];

  logic signed [CW-1:0] x0, y0;
  logic [AW-1:0]        z0, qsum;
  logic [1:0]           q;
  logic                 flag0;

  // Rotation: fold the angle into plus or minus an eighth turn by a quarter-turn swap.
  // Vectoring: move the vector into the right half plane; a zero vector is flagged.
  always_comb begin
    x0 = in_x;
    y0 = in_y;
    z0 = in_ang;
    qsum = in_ang + (QUARTER >> 1);
    q = qsum[AW-1 -: 2];
    flag0 = VECTOR ? (in_x == '0 && in_y == '0) : in_flag;
    if (VECTOR) begin
      if (in_x < 0) begin
        x0 = -in_x;
        y0 = -in_y;
        z0 = HALF_TURN;
      end else begin
        z0 = '0;
      end
    end else begin
      z0 = in_ang - {q, {(AW-2){1'b0}}};
      case (q)
        2'd1: begin
          x0 = -in_y;
          y0 = in_x;
        end
        2'd2: begin
          x0 = -in_x;
          y0 = -in_y;
        end
        2'd3: begin
          x0 = in_y;
          y0 = -in_x;
        end
        default: begin
          x0 = in_x;
          y0 = in_y;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      x_r[0] <= x0;
      y_r[0] <= y0;
      z_r[0] <= z0;
      xo_r[0] <= in_x;
      yo_r[0] <= in_y;
      flag_r[0] <= flag0;
      sb_r[0] <= in_sb;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [AW-1:0] ATAN_I = atan_entry(i);
    logic signed [CW-1:0] dx, dy;
    logic plus;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign plus = VECTOR ? ~y_r[i][CW-1] : z_r[i][AW-1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        if (plus) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end
        xo_r[i+1] <= xo_r[i];
        yo_r[i+1] <= yo_r[i];
        flag_r[i+1] <= flag_r[i];
        sb_r[i+1] <= sb_r[i];
      end
    end
  end

  // Gain compensation: multiply by 1/K in Q30, floor shift by 30 at the output.
  logic signed [CW+30:0] px_r, py_r;
  logic signed [CW-1:0]  xf_r, yf_r;
  logic [AW-1:0]         af_r;
  logic                  ff_r, vf_r;
  logic [SBW-1:0]        sbf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v_r[STAGES];
    end
    if (en) begin
      px_r <= x_r[STAGES] * INV_GAIN;
      py_r <= y_r[STAGES] * INV_GAIN;
      xf_r <= xo_r[STAGES];
      yf_r <= yo_r[STAGES];
      af_r <= z_r[STAGES];
      ff_r <= flag_r[STAGES];
      sbf_r <= sb_r[STAGES];
    end
  end

  assign out_valid = vf_r;
  assign out_sb = sbf_r;
  assign out_x = (!VECTOR && ff_r) ? xf_r : px_r[30 +: CW];
  assign out_y = (!VECTOR && ff_r) ? yf_r : py_r[30 +: CW];
  assign out_ang = (VECTOR && ff_r) ? '0 : af_r;

endmodule
`default_nettype wire

[src/celestial_coordinate_converter.sv]
// Top level of the celestial coordinate converter: a chain of pipelined CORDIC units.
//
//  Port group  Direction  Handshake          Carries
//  in_         in         in_valid/in_stall  mode, angle_lon, angle_lat, sidereal_time
//  out_        out        out_valid/out_stall out_lon, out_lat
//  cfg_        in         cfg_valid/cfg_ready site latitude
//
// One item enters per cycle while the output is not stalled; the pipeline is the seven
// chained CORDIC units (five rotations, two vectorings) followed by the output register.
// Reset (synchronous, rst_n low) clears all valid bits and sets the latitude to zero.
// A stall on a valid output freezes the whole pipeline and stalls the input in the same cycle.
// Requests with an undefined mode are accepted and produce no result.
`timescale 1ns / 1ps
`default_nettype none
module celestial_coordinate_converter import ccc_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_mode,
  input  logic [ANGLE_BITS-1:0]        in_angle_lon,
  input  logic signed [ANGLE_BITS-1:0] in_angle_lat,
  input  logic [ANGLE_BITS-1:0]        in_sidereal_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ANGLE_BITS-1:0]        out_lon,
  output logic signed [ANGLE_BITS-1:0] out_lat,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic signed [ANGLE_BITS-1:0] cfg_data
);

  localparam int UP = AW - ANGLE_BITS;
  localparam logic [AW-1:0] RND = AW'(64'd1) << (UP - 1);

  typedef struct packed {
    logic [2:0]            mode;
    logic [ANGLE_BITS-1:0] lon;
    logic [ANGLE_BITS-1:0] lat;
    logic [ANGLE_BITS-1:0] sid;
    logic signed [CW-1:0]  ca;
    logic [AW-1:0]         ang;
  } item_t;

  localparam int SBW = $bits(item_t);

  logic [ANGLE_BITS-1:0] site_lat_r;
  logic en;
  logic [AW-1:0] phi;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_lat_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      site_lat_r <= cfg_data;
    end
  end
  assign phi = {site_lat_r, {UP{1'b0}}};

  logic out_valid_r, out_swap_r;
  logic [ANGLE_BITS-1:0] out_lon_r, out_lat_r;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  item_t s0, s1i, s1, s2i, s2, s3i, s3, s4i, s4, s5i, s5, s6i, s6, s7;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [CW-1:0] x1, y1, x2, y2, x3, z3, x4, y4r, y4, x5, z5, r6, u6, m7, u7;
  logic [AW-1:0] a1, a2, a3, a4, a5, olon6, olat7;
  logic in_ok, byp3, byp4, byp5, flip4;

  assign in_ok = in_valid && (in_mode <= MODE_EQ2_HOR);
  always_comb begin
    s0.mode = in_mode;
    s0.lon = in_angle_lon;
    s0.lat = in_angle_lat;
    s0.sid = in_sidereal_time;
    s0.ca = '0;
    s0.ang = '0;
  end

  // Unit vector from the latitude-like angle: cos in x, sin in y.
  ccc_cordic #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_lat (
    .clk, .rst_n, .en, .in_valid(in_ok), .in_flag(1'b0),
    .in_x(ONE_Q30), .in_y('0), .in_ang({in_angle_lat, {UP{1'b0}}}), .in_sb(s0),
    .out_valid(v1), .out_x(x1), .out_y(y1), .out_ang(a1), .out_sb(s1i)
  );

  always_comb begin
    s1 = s1i;
    s1.ca = y1;
  end

  ccc_cordic #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_lon (
    .clk, .rst_n, .en, .in_valid(v1), .in_flag(1'b0),
    .in_x(x1), .in_y('0), .in_ang({s1.lon, {UP{1'b0}}}), .in_sb(s1),
    .out_valid(v2), .out_x(x2), .out_y(y2), .out_ang(a2), .out_sb(s2i)
  );

  // The z component rides in the side record while (x,y) is turned, and the other way.
  always_comb begin
    s2 = s2i;
    s2.ca = y2;
    byp3 = !(s2i.mode == MODE_HOR_EQ1 || s2i.mode == MODE_HOR_EQ2);
  end

  ccc_cordic #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_tilt_in (
    .clk, .rst_n, .en, .in_valid(v2), .in_flag(byp3),
    .in_x(x2), .in_y(s2i.ca), .in_ang(phi - QUARTER), .in_sb(s2),
    .out_valid(v3), .out_x(x3), .out_y(z3), .out_ang(a3), .out_sb(s3i)
  );

  always_comb begin
    s3 = s3i;
    s3.ca = z3;
    byp4 = !(s3i.mode == MODE_HOR_EQ2 || s3i.mode == MODE_EQ2_HOR);
  end

  ccc_cordic #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_sid (
    .clk, .rst_n, .en, .in_valid(v3), .in_flag(byp4),
    .in_x(x3), .in_y(s3i.ca), .in_ang(AW'(0) - {s3i.sid, {UP{1'b0}}}), .in_sb(s3),
    .out_valid(v4), .out_x(x4), .out_y(y4r), .out_ang(a4), .out_sb(s4i)
  );

  always_comb begin
    flip4 = (s4i.mode == MODE_HOR_EQ2 || s4i.mode == MODE_EQ2_HOR);
    y4 = flip4 ? -y4r : y4r;
    s4 = s4i;
    s4.ca = y4;
    byp5 = !(s4i.mode == MODE_EQ1_HOR || s4i.mode == MODE_EQ2_HOR);
  end

  ccc_cordic #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_tilt_out (
    .clk, .rst_n, .en, .in_valid(v4), .in_flag(byp5),
    .in_x(x4), .in_y(s4i.ca), .in_ang(QUARTER - phi), .in_sb(s4),
    .out_valid(v5), .out_x(x5), .out_y(z5), .out_ang(a5), .out_sb(s5i)
  );

  always_comb begin
    s5 = s5i;
    s5.ca = z5;
  end

  ccc_cordic #(.VECTOR(1'b1), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_vec_lon (
    .clk, .rst_n, .en, .in_valid(v5), .in_flag(1'b0),
    .in_x(x5), .in_y(s5i.ca), .in_ang('0), .in_sb(s5),
    .out_valid(v6), .out_x(r6), .out_y(u6), .out_ang(olon6), .out_sb(s6i)
  );

  // Near the pole the longitude is meaningless and is reported as zero.
  always_comb begin
    s6 = s6i;
    s6.ang = (r6 < POLE_EPS) ? '0 : olon6;
  end

  ccc_cordic #(.VECTOR(1'b1), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_vec_lat (
    .clk, .rst_n, .en, .in_valid(v6), .in_flag(1'b0),
    .in_x(r6), .in_y(s6i.ca), .in_ang('0), .in_sb(s6),
    .out_valid(v7), .out_x(m7), .out_y(u7), .out_ang(olat7), .out_sb(s7)
  );

  logic [AW-1:0] olat_sat, lon_rnd, lat_rnd;
  logic [ANGLE_BITS-1:0] lon_fin, lat_fin;
  logic swap7;

  always_comb begin
    olat_sat = olat7;
    if (olat7 > QUARTER && olat7 < HALF_TURN) begin
      olat_sat = QUARTER;
    end else if (olat7 >= HALF_TURN && olat7 < THREE_QUARTER) begin
      olat_sat = THREE_QUARTER;
    end
    lon_rnd = s7.ang + RND;
    lat_rnd = olat_sat + RND;
    swap7 = (s7.mode == MODE_EQ_SWAP);
    lon_fin = swap7 ? (s7.sid - s7.lon) : lon_rnd[AW-1 -: ANGLE_BITS];
    lat_fin = swap7 ? s7.lat : lat_rnd[AW-1 -: ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v7;
    end
    if (en && v7) begin
      out_lon_r <= lon_fin;
      out_lat_r <= lat_fin;
      out_swap_r <= swap7;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lon = out_lon_r;
  assign out_lat = out_lat_r;

  localparam logic signed [ANGLE_BITS-1:0] QTR_F = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid set right after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v7))
    else $error("pipeline advanced during an output stall");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_swap_r) |->
      ($signed(out_lat_r) <= QTR_F && $signed(out_lat_r) >= -QTR_F))
    else $error("converted latitude beyond a quarter turn");

  logic unused_ok;
  assign unused_ok = ^{a1, a2, a3, a4, a5, m7, u6, u7};

endmodule
`default_nettype wire

[dv/tb_celestial_coordinate_converter.sv]
// Self-checking testbench for the celestial coordinate converter, with a bit-true predictor.
`timescale 1ns / 1ps
module tb_celestial_coordinate_converter;
  import ccc_pkg::*;

  localparam int STAGES = 30;
  localparam int DRAIN_CYCLES = 7 * (STAGES + 2) + 20;
  localparam int HOLD_CYCLES = 500;
  localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
  localparam logic [63:0] Q64_INV_TWO_PI = 64'h28BE_60DB_9391_054A;
  localparam longint COMP_GAIN = 64'sh26DD3B6A;
  localparam logic [63:0] TURN_QUARTER = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TURN_HALF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TURN_3Q = 64'hC000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] lon;
    logic [31:0] lat;
  } sky_pos_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [31:0] sid;
    bit          typed;
    sky_pos_t    pos;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [31:0] in_angle_lon = '0;
  logic signed [31:0] in_angle_lat = '0;
  logic [31:0] in_sidereal_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_lon;
  logic signed [31:0] out_lat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [31:0] cfg_data = '0;

  logic [63:0] atan_turns [STAGES];
  logic [31:0] site_lat;
  sky_pos_t pending_pos [$];
  int errors = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit long_hold_req = 1'b0;

  celestial_coordinate_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_angle_lon(in_angle_lon), .in_angle_lat(in_angle_lat),
    .in_sidereal_time(in_sidereal_time),
    .out_valid(out_valid), .out_stall(out_stall), .out_lon(out_lon), .out_lat(out_lat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #100ms;
    $display("FAIL celestial_coordinate_converter");
    $finish;
  end

  // Arctangent of 2^-i in 2^-64 turns, from a truncated series times 1/(2 pi).
  initial begin
    logic [63:0] acc;
    logic [63:0] term;
    logic [127:0] prod;
    atan_turns[0] = 64'h2000_0000_0000_0000;
    for (int i = 1; i < STAGES; i++) begin
      acc = '0;
      for (int k = 0; i * (2 * k + 1) <= 63; k++) begin
        term = (64'd1 << (64 - i * (2 * k + 1))) / 64'(2 * k + 1);
        acc = (k % 2 == 1) ? acc - term : acc + term;
      end
      prod = {64'd0, acc} * {64'd0, Q64_INV_TWO_PI};
      atan_turns[i] = prod[127:64];
    end
  end

  function automatic longint gain_fix(longint v);
    return (v * COMP_GAIN) >>> 30;
  endfunction

  function automatic void cordic_turn(inout longint x, inout longint y, input logic [63:0] th);
    logic [63:0] q;
    logic [63:0] z;
    longint t;
    longint dx;
    longint dy;
    q = ((th + (TURN_QUARTER >> 1)) >> 62) & 64'd3;
    z = th - (q << 62);
    if (q == 1) begin
      t = x; x = -y; y = t;
    end else if (q == 2) begin
      x = -x; y = -y;
    end else if (q == 3) begin
      t = x; x = y; y = -t;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z[63]) begin
        x += dx; y -= dy; z += atan_turns[i];
      end else begin
        x -= dx; y += dy; z -= atan_turns[i];
      end
    end
    x = gain_fix(x);
    y = gain_fix(y);
  endfunction

  function automatic logic [63:0] cordic_angle(input longint xi, input longint yi,
                                                output longint mag);
    logic [63:0] acc;
    longint x;
    longint y;
    longint dx;
    longint dy;
    acc = '0;
    x = xi;
    y = yi;
    if (x == 0 && y == 0) begin
      mag = 0;
      return '0;
    end
    if (x < 0) begin
      x = -x; y = -y; acc = TURN_HALF;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += atan_turns[i];
      end else begin
        x -= dx; y += dy; acc -= atan_turns[i];
      end
    end
    mag = gain_fix(x);
    return acc;
  endfunction

  function automatic logic [31:0] round_turn(logic [63:0] a);
    logic [63:0] r;
    r = (a + 64'h8000_0000) >> 32;
    return r[31:0];
  endfunction

  function automatic sky_pos_t convert_pos(logic [2:0] mode, logic [31:0] lon,
                                           logic [31:0] lat, logic [31:0] sid);
    logic [63:0] phi;
    logic [63:0] olon;
    logic [63:0] olat;
    longint cv;
    longint sv;
    longint x;
    longint y;
    longint z;
    longint r;
    longint m;
    sky_pos_t p;
    phi = {site_lat, 32'd0};
    if (mode == MODE_EQ_SWAP) begin
      p.lon = sid - lon;
      p.lat = lat;
      return p;
    end
    cv = 64'sd1 << 30;
    sv = 0;
    cordic_turn(cv, sv, {lat, 32'd0});
    x = cv;
    y = 0;
    cordic_turn(x, y, {lon, 32'd0});
    z = sv;
    if (mode == MODE_HOR_EQ1 || mode == MODE_HOR_EQ2) cordic_turn(x, z, phi - TURN_QUARTER);
    if (mode == MODE_HOR_EQ2 || mode == MODE_EQ2_HOR) begin
      cordic_turn(x, y, 64'd0 - {sid, 32'd0});
      y = -y;
    end
    if (mode == MODE_EQ1_HOR || mode == MODE_EQ2_HOR) cordic_turn(x, z, TURN_QUARTER - phi);
    olon = cordic_angle(x, y, r);
    if (r < 64) olon = '0;
    olat = cordic_angle(r, z, m);
    // CORDIC error can push the latitude past the pole; clamp it back.
    if (olat > TURN_QUARTER && olat < TURN_HALF) olat = TURN_QUARTER;
    else if (olat >= TURN_HALF && olat < TURN_3Q) olat = TURN_3Q;
    p.lon = round_turn(olon);
    p.lat = round_turn(olat);
    return p;
  endfunction

  task automatic send_request(logic [2:0] mode, logic [31:0] lon, logic [31:0] lat,
                              logic [31:0] sid, bit typed, sky_pos_t pos);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_angle_lon <= lon;
    in_angle_lat <= lat;
    in_sidereal_time <= sid;
    do @(posedge clk); while (in_stall);
    if (mode <= MODE_EQ2_HOR) pending_pos.push_back(typed ? pos : convert_pos(mode, lon, lat, sid));
    if (sender_idles && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_site_lat(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    site_lat = v;
  endtask

  task automatic random_requests(int n);
    logic [2:0] mode;
    sky_pos_t none;
    none = '0;
    for (int i = 0; i < n; ) begin
      mode = ($urandom_range(15) == 0) ? 3'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO))
                                       : 3'($urandom_range(MODE_EQ2_HOR, MODE_HOR_EQ1));
      send_request(mode, $urandom, ($urandom_range(3) == 0) ? $urandom
                   : 32'($urandom_range(32'h8000_0000) - 32'h4000_0000), $urandom, 1'b0, none);
      if (mode <= MODE_EQ2_HOR) i++;
    end
  endtask

  // Receiver side: random stall bursts, and one long hold to back the pipeline up.
  initial begin
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (receiver_idles && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sky_pos_t exp_pos;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pos.size() == 0) begin
        $display("%0t: unexpected result lon=%h lat=%h", $time, out_lon, out_lat);
        errors++;
      end else begin
        exp_pos = pending_pos.pop_front();
        if (out_lon !== exp_pos.lon) begin
          $display("%0t: out_lon expected %h actual %h", $time, exp_pos.lon, out_lon);
          errors++;
        end
        if (out_lat !== exp_pos.lat) begin
          $display("%0t: out_lat expected %h actual %h", $time, exp_pos.lat, out_lat);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    logic [31:0] site_settings [5];
    rows = '{
      '{MODE_EQ_SWAP, 32'h0000_0001, 32'h4000_0000, 32'h0000_0000, 1'b1,
        '{32'hFFFF_FFFF, 32'h4000_0000}},
      '{MODE_EQ_SWAP, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 32'h8000_0000}},
      '{MODE_EQ_SWAP, 32'hFFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF, 1'b1,
        '{32'h0000_0000, 32'hC000_0000}},
      '{MODE_HOR_EQ1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{MODE_HOR_EQ1, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_0000, 1'b0, '0},
      '{MODE_HOR_EQ1, 32'h4000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_EQ1_HOR, 32'h0000_0000, 32'h4000_0000, 32'h0000_0000, 1'b0, '0},
      '{MODE_EQ1_HOR, 32'h8000_0000, 32'hC000_0000, 32'h0000_0000, 1'b0, '0},
      '{MODE_EQ1_HOR, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, '0},
      '{MODE_HOR_EQ2, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_HOR_EQ2, 32'hC000_0000, 32'h4000_0000, 32'h8000_0000, 1'b0, '0},
      '{MODE_HOR_EQ2, 32'h2000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
      '{MODE_EQ2_HOR, 32'h0000_0000, 32'hC000_0000, 32'h0000_0000, 1'b0, '0},
      '{MODE_EQ2_HOR, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_EQ2_HOR, 32'h6000_0000, 32'hBFFF_FFFF, 32'h4000_0000, 1'b0, '0},
      '{MODE_UNDEF_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_UNDEF_HI, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };
    site_settings = '{32'h4000_0000, 32'hC000_0000, $urandom, $urandom, 32'h0000_0000};
    site_lat = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send_request(rows[i].mode, rows[i].lon, rows[i].lat, rows[i].sid, rows[i].typed,
                   rows[i].pos);
    drain_pipe();
    write_site_lat(32'h1555_5555);
    foreach (rows[i])
      if (!rows[i].typed)
        send_request(rows[i].mode, rows[i].lon, rows[i].lat, rows[i].sid, 1'b0, '0);
    random_requests(200);
    drain_pipe();
    foreach (site_settings[i]) begin
      write_site_lat(site_settings[i]);
      if (i == 1) begin
        // Keep the sender busy while the receiver holds off, so the pipeline fills.
        sender_idles = 1'b0;
        long_hold_req = 1'b1;
        random_requests(300);
        sender_idles = 1'b1;
      end else if (i == 4) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        random_requests(330);
      end else begin
        random_requests(330);
      end
      drain_pipe();
    end
    if (errors == 0) begin
      $display("PASS celestial_coordinate_converter");
    end else begin
      $display("FAIL celestial_coordinate_converter");
    end
    $finish;
  end

endmodule
